// ----- sv/llq_pkg.sv -----
// Shared types, codes and constants for the linked list deque manager.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
// Depends on nothing.
package llq_pkg;

   // Default number of node slots.
   localparam int LLQ_CAPACITY = 16;

   // Fixed field widths of the request and response payloads.
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int HANDLE_W = 4;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_code_type;
   typedef logic [3:0]          dp_op_type;

   // Request commands.
   localparam cmd_type CMD_PUSH_BACK  = 3'd0;
   localparam cmd_type CMD_PUSH_FRONT = 3'd1;
   localparam cmd_type CMD_POP_BACK   = 3'd2;
   localparam cmd_type CMD_POP_FRONT  = 3'd3;
   localparam cmd_type CMD_REMOVE     = 3'd4;
   localparam cmd_type CMD_FIND       = 3'd5;

   // Response status codes.
   localparam status_code_type ST_DONE      = 2'd0;
   localparam status_code_type ST_EMPTY     = 2'd1;
   localparam status_code_type ST_NOT_FOUND = 2'd2;
   localparam status_code_type ST_INVALID   = 2'd3;

   // Datapath operations issued by the controller, one per cycle.
   localparam dp_op_type OP_NONE       = 4'd0;
   localparam dp_op_type OP_CAPTURE    = 4'd1;
   localparam dp_op_type OP_SET_STATUS = 4'd2;
   localparam dp_op_type OP_SCAN_INIT  = 4'd3;
   localparam dp_op_type OP_SCAN_STEP  = 4'd4;
   localparam dp_op_type OP_PUSH       = 4'd5;
   localparam dp_op_type OP_PTR_TAIL   = 4'd6;
   localparam dp_op_type OP_PTR_HEAD   = 4'd7;
   localparam dp_op_type OP_PTR_HANDLE = 4'd8;
   localparam dp_op_type OP_UNLINK     = 4'd9;
   localparam dp_op_type OP_WALK_INIT  = 4'd10;
   localparam dp_op_type OP_WALK_CHECK = 4'd11;
   localparam dp_op_type OP_LOAD_OUT   = 4'd12;

   // Controller to datapath.
   typedef struct packed {
      dp_op_type       op;
      status_code_type status;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      cmd_type command;
      logic    list_empty;
      logic    list_full;
      logic    handle_bad;
      logic    slot_free;
      logic    value_match;
      logic    walk_last;
   } dp_stat_type;

endpackage

// ----- sv/llq_req_if.sv -----
// Request channel of the linked list deque manager: valid, ready and payload.
// Depends on llq_pkg.
interface llq_req_if import llq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [VALUE_W-1:0] item_value;
   logic [HANDLE_W-1:0]       slot_handle;

   modport source (output valid, command, item_value, slot_handle, input ready);
   modport sink   (input valid, command, item_value, slot_handle, output ready);
endinterface

// ----- sv/llq_rsp_if.sv -----
// Response channel of the linked list deque manager: valid, ready and payload.
// Depends on llq_pkg.
interface llq_rsp_if import llq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   result_slot;
   logic [COUNT_W-1:0]  element_count;

   modport source (output valid, status, result_slot, element_count, input ready);
   modport sink   (input valid, status, result_slot, element_count, output ready);
endinterface

// ----- sv/llq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module llq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read in the same clock.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/llq_datapath.sv -----
// Datapath of the linked list deque manager: node stores, occupancy map,
// head, tail and length, walk pointer and the response register.
// Depends on llq_pkg and llq_ram.
module llq_datapath import llq_pkg::*; #(
   parameter int CAPACITY = LLQ_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              ctrl,
   output dp_stat_type               stat,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [HANDLE_W-1:0]       req_slot_handle,
   output logic [STATUS_W-1:0]       out_status,
   output logic [SLOT_W-1:0]         out_slot,
   output logic [COUNT_W-1:0]        out_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Captured request.
   cmd_type                   cmd_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [HANDLE_W-1:0]       handle_ff;

   // List control state.
   logic [CAPACITY-1:0] in_use_ff, in_use_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       len_ff, len_in;

   // Working pointer, walk count and staged result.
   logic [IW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   status_code_type res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;

   // Response register.
   status_code_type    out_status_ff, out_status_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   // RAM ports.
   logic [IW-1:0]      rd_addr;
   logic [VALUE_W-1:0] val_rd;
   logic [IW-1:0]      nxt_rd, prv_rd;
   logic               val_we, nxt_we, prv_we;
   logic [IW-1:0]      val_wa, nxt_wa, prv_wa;
   logic [IW-1:0]      nxt_wd, prv_wd;

   logic list_empty, list_single, value_match, walk_last, walk_adv, handle_bad;

   // Status towards the controller.
   assign list_empty  = (len_ff == '0);
   assign list_single = (len_ff == CW'(1));
   assign value_match = (val_rd == val_ff);
   assign walk_last   = ((cnt_ff + CW'(1)) == len_ff);
   assign walk_adv    = (ctrl.op == OP_WALK_CHECK) && !value_match && !walk_last;
   assign handle_bad  = (32'(handle_ff) >= CAPACITY) || !in_use_ff[IW'(handle_ff)];

   always_comb begin
      stat.command     = cmd_ff;
      stat.list_empty  = list_empty;
      stat.list_full   = (len_ff == CW'(CAPACITY));
      stat.handle_bad  = handle_bad;
      stat.slot_free   = !in_use_ff[ptr_ff];
      stat.value_match = value_match;
      stat.walk_last   = walk_last;
   end

   // During a walk the next node is read straight from the link store output.
   assign rd_addr = walk_adv ? nxt_rd : ptr_ff;

   // Store writes for push and unlink.
   always_comb begin
      val_we = 1'b0;
      nxt_we = 1'b0;
      prv_we = 1'b0;
      val_wa = ptr_ff;
      nxt_wa = ptr_ff;
      prv_wa = ptr_ff;
      nxt_wd = ptr_ff;
      prv_wd = ptr_ff;
      if (ctrl.op == OP_PUSH) begin
         val_we = 1'b1;
         if (!list_empty) begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
            if (cmd_ff == CMD_PUSH_BACK) begin
               prv_wd = tail_ff;
               nxt_wa = tail_ff;
            end else begin
               nxt_wd = head_ff;
               prv_wa = head_ff;
            end
         end
      end else if (ctrl.op == OP_UNLINK && !list_single &&
                   ptr_ff != head_ff && ptr_ff != tail_ff) begin
         nxt_we = 1'b1;
         nxt_wa = prv_rd;
         nxt_wd = nxt_rd;
         prv_we = 1'b1;
         prv_wa = nxt_rd;
         prv_wd = prv_rd;
      end
   end

   llq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   llq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   llq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   // Next-state logic for list state, pointer and result.
   always_comb begin
      in_use_in     = in_use_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      len_in        = len_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_count_in  = out_count_ff;
      unique case (ctrl.op)
         OP_SET_STATUS: begin
            res_status_in = ctrl.status;
            res_slot_in   = '0;
         end
         OP_SCAN_INIT: ptr_in = '0;
         OP_SCAN_STEP: ptr_in = ptr_ff + IW'(1);
         OP_PUSH: begin
            in_use_in[ptr_ff] = 1'b1;
            len_in            = len_ff + CW'(1);
            if (list_empty) begin
               head_in = ptr_ff;
               tail_in = ptr_ff;
            end else if (cmd_ff == CMD_PUSH_BACK) begin
               tail_in = ptr_ff;
            end else begin
               head_in = ptr_ff;
            end
            res_status_in = ST_DONE;
            res_slot_in   = SLOT_W'(ptr_ff);
         end
         OP_PTR_TAIL:   ptr_in = tail_ff;
         OP_PTR_HEAD:   ptr_in = head_ff;
         OP_PTR_HANDLE: ptr_in = IW'(handle_ff);
         OP_UNLINK: begin
            in_use_in[ptr_ff] = 1'b0;
            len_in            = len_ff - CW'(1);
            if (list_single) begin
               head_in = '0;
               tail_in = '0;
            end else if (ptr_ff == head_ff) begin
               head_in = nxt_rd;
            end else if (ptr_ff == tail_ff) begin
               tail_in = prv_rd;
            end
            res_status_in = ST_DONE;
            res_slot_in   = '0;
         end
         OP_WALK_INIT: begin
            ptr_in = head_ff;
            cnt_in = '0;
         end
         OP_WALK_CHECK: begin
            if (value_match) begin
               res_status_in = ST_DONE;
               res_slot_in   = SLOT_W'(ptr_ff);
            end else if (walk_last) begin
               res_status_in = ST_NOT_FOUND;
               res_slot_in   = '0;
            end else begin
               ptr_in = nxt_rd;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         OP_LOAD_OUT: begin
            out_status_in = res_status_ff;
            out_slot_in   = res_slot_ff;
            out_count_in  = COUNT_W'(len_ff);
         end
         default: begin
         end
      endcase
   end

   // Control state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         len_ff    <= '0;
      end else begin
         in_use_ff <= in_use_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         len_ff    <= len_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_CAPTURE) begin
         cmd_ff    <= req_command;
         val_ff    <= req_item_value;
         handle_ff <= req_slot_handle;
      end
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_count_ff  <= out_count_in;
   end

   assign out_status = out_status_ff;
   assign out_slot   = out_slot_ff;
   assign out_count  = out_count_ff;

endmodule

// ----- sv/llq_ctrl.sv -----
// Controller of the linked list deque manager: sequences each command
// through the datapath and owns the request and response handshakes.
// Depends on llq_pkg.
module llq_ctrl import llq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type ctrl
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_LINK_RD  = 3'd3;
   localparam logic [2:0] S_UNLINK   = 3'd4;
   localparam logic [2:0] S_WALK_RD  = 3'd5;
   localparam logic [2:0] S_WALK_CHK = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // State transitions and the datapath operation for this cycle.
   always_comb begin
      state_in    = state_ff;
      ctrl.op     = OP_NONE;
      ctrl.status = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.op  = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            unique case (stat.command) inside
               CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                  if (stat.list_full) begin
                     ctrl.op     = OP_SET_STATUS;
                     ctrl.status = ST_INVALID;
                  end else begin
                     ctrl.op  = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               CMD_POP_BACK, CMD_POP_FRONT: begin
                  if (stat.list_empty) begin
                     ctrl.op     = OP_SET_STATUS;
                     ctrl.status = ST_EMPTY;
                  end else begin
                     ctrl.op  = (stat.command == CMD_POP_BACK) ? OP_PTR_TAIL : OP_PTR_HEAD;
                     state_in = S_LINK_RD;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.list_empty) begin
                     ctrl.op     = OP_SET_STATUS;
                     ctrl.status = ST_EMPTY;
                  end else if (stat.handle_bad) begin
                     ctrl.op     = OP_SET_STATUS;
                     ctrl.status = ST_INVALID;
                  end else begin
                     ctrl.op  = OP_PTR_HANDLE;
                     state_in = S_LINK_RD;
                  end
               end
               CMD_FIND: begin
                  if (stat.list_empty) begin
                     ctrl.op     = OP_SET_STATUS;
                     ctrl.status = ST_NOT_FOUND;
                  end else begin
                     ctrl.op  = OP_WALK_INIT;
                     state_in = S_WALK_RD;
                  end
               end
               default: begin
                  // Undefined commands answer done and change nothing.
                  ctrl.op     = OP_SET_STATUS;
                  ctrl.status = ST_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.slot_free) begin
               ctrl.op  = OP_PUSH;
               state_in = S_FINISH;
            end else begin
               ctrl.op = OP_SCAN_STEP;
            end
         end
         S_LINK_RD: state_in = S_UNLINK;
         S_UNLINK: begin
            ctrl.op  = OP_UNLINK;
            state_in = S_FINISH;
         end
         S_WALK_RD: state_in = S_WALK_CHK;
         S_WALK_CHK: begin
            ctrl.op = OP_WALK_CHECK;
            if (stat.value_match || stat.walk_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               ctrl.op  = OP_LOAD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The response stays valid until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.op == OP_LOAD_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/linked_list_deque_manager.sv -----
// Channel   Role   Handshake            Payload
// req_bus   sink   valid/ready          command, item_value, slot_handle
// rsp_bus   source valid/ready          status, result_slot, element_count
//
// One request is worked on at a time; a finished response sits in an output
// register, so the next request is taken while the response waits.
// Push: the lowest free slot is found by the one-slot-per-cycle occupancy scan.
// Pop and remove: one link read.
// Find: nodes are visited in list order, one node store read per cycle.
// Synchronous reset empties the list at once; no clearing pass is needed.
// A stalled response holds the next request in the finish state until it is taken.
// Depends on llq_pkg, llq_req_if, llq_rsp_if, llq_ctrl and llq_datapath.
module linked_list_deque_manager import llq_pkg::*; #(
   parameter int CAPACITY = LLQ_CAPACITY
) (
   input logic clock,
   input logic reset,
   llq_req_if.sink   req_bus,
   llq_rsp_if.source rsp_bus
);

   ctrl_cmd_type ctrl;
   dp_stat_type  stat;

   llq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   llq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_command     (req_bus.command),
      .req_item_value  (req_bus.item_value),
      .req_slot_handle (req_bus.slot_handle),
      .out_status      (rsp_bus.status),
      .out_slot        (rsp_bus.result_slot),
      .out_count       (rsp_bus.element_count)
   );

endmodule

// ----- sv/llq_checker.sv -----
// Port-level checks for the linked list deque manager, bound to the top level.
// Depends on llq_pkg and linked_list_deque_manager.
module llq_checker import llq_pkg::*; #(
   parameter int CAPACITY = LLQ_CAPACITY
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic [COUNT_W-1:0]  rsp_count
);

   // A stalled response keeps its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_slot) && $stable(rsp_count))
      else $error("response changed while stalled");

   // An empty-list no-op reports a count of zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with non-zero count");

   // Any status other than done carries slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_slot == '0)
      else $error("failed request reported a slot");

   // The count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY >= 32) || (32'(rsp_count) <= CAPACITY))
      else $error("element count beyond capacity");

endmodule

bind linked_list_deque_manager llq_checker #(.CAPACITY(CAPACITY)) u_llq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_slot   (rsp_bus.result_slot),
   .rsp_count  (rsp_bus.element_count)
);
